// ===== rtl/core/bba_pkg.sv =====
package bba_pkg;

    // field and register widths
    localparam int ID_W     = 10;
    localparam int CNT_W    = 11;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 11;

    // bitmap word geometry
    localparam int WORD_W     = 64;
    localparam int WORD_SEL_W = 6;

    // block indices never exceed the result range
    localparam int ID_LIMIT       = 1024;
    localparam int MAX_BLOCKS_DEF = 1024;

    // register reset values
    localparam logic [ID_W-1:0]  FIRST_FREE_RST  = 10'd1;
    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = 11'd1024;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_FREE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

    // commands
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOCATED = 2'd0,
        ST_FULL      = 2'd1,
        ST_FREED     = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic scan_rd;
        logic free_rd;
        logic alloc_wr;
        logic free_wr;
        logic set_full;
        logic set_range;
        logic out_load;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_free;
        logic window_empty;
        logic free_in_range;
        logic ex_vld;
        logic hit;
        logic ex_last;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== rtl/core/bba_ctrl.sv =====
module bba_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bba_pkg::dp_stat_t   stat,
    output bba_pkg::dp_cmd_t    cmd
);

    bba_pkg::state_t state_reg;
    bba_pkg::state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = bba_pkg::S_START;
                end
            end
            bba_pkg::S_START:
            begin
                if (stat.item_free)
                begin
                    state_next = stat.free_in_range ? bba_pkg::S_FREE_RD : bba_pkg::S_DONE;
                end
                else
                begin
                    state_next = stat.window_empty ? bba_pkg::S_DONE : bba_pkg::S_SCAN;
                end
            end
            bba_pkg::S_SCAN:
            begin
                if (stat.ex_vld && (stat.hit || stat.ex_last))
                begin
                    state_next = bba_pkg::S_DONE;
                end
            end
            bba_pkg::S_FREE_RD:
            begin
                state_next = bba_pkg::S_FREE_WR;
            end
            bba_pkg::S_FREE_WR:
            begin
                state_next = bba_pkg::S_DONE;
            end
            bba_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    state_next = bba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            bba_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = in_valid;
            end
            bba_pkg::S_START:
            begin
                if (stat.item_free)
                begin
                    cmd.set_range = !stat.free_in_range;
                end
                else
                begin
                    cmd.set_full = stat.window_empty;
                end
            end
            bba_pkg::S_SCAN:
            begin
                cmd.scan_rd  = 1'b1;
                cmd.alloc_wr = stat.ex_vld && stat.hit;
                cmd.set_full = stat.ex_vld && !stat.hit && stat.ex_last;
            end
            bba_pkg::S_FREE_RD:
            begin
                cmd.free_rd = 1'b1;
            end
            bba_pkg::S_FREE_WR:
            begin
                cmd.free_wr = 1'b1;
            end
            bba_pkg::S_DONE:
            begin
                cmd.out_load = !stat.out_busy;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/core/bba_dpath.sv =====
module bba_dpath #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            command,
    input  logic [bba_pkg::ID_W-1:0]        block_id,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bba_pkg::ID_W-1:0]        result_block,
    output logic [bba_pkg::STATUS_W-1:0]    status,
    input  bba_pkg::dp_cmd_t                cmd,
    output bba_pkg::dp_stat_t               stat
);

    localparam int NBITS = (MAX_BLOCKS < bba_pkg::ID_LIMIT) ? MAX_BLOCKS : bba_pkg::ID_LIMIT;
    localparam int WORDS = (NBITS + bba_pkg::WORD_W - 1) / bba_pkg::WORD_W;
    localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int WW    = bba_pkg::WORD_W;
    localparam int SW    = bba_pkg::WORD_SEL_W;
    localparam int CW    = bba_pkg::CNT_W;
    localparam int IW    = bba_pkg::ID_W;

    // configuration registers
    logic [IW-1:0] first_free_reg;
    logic [CW-1:0] block_count_reg;

    // current item
    logic          item_cmd_reg;
    logic [IW-1:0] item_id_reg;

    // bitmap memory and per-word written flags
    logic [WW-1:0] mem [WORDS];
    logic [WORDS-1:0] wvalid_reg;

    // read pipeline
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] ex_ptr_reg;
    logic [WW-1:0] rd_data_reg;
    logic          rd_wvld_reg;
    logic          ex_vld_reg;

    // result and output registers
    logic [IW-1:0]    res_block_reg;
    bba_pkg::status_t res_status_reg;
    logic [IW-1:0]    out_block_reg;
    bba_pkg::status_t out_status_reg;
    logic             out_valid_reg;

    // window and scan helpers
    logic [CW-1:0] lim;
    logic [CW-1:0] lim_m1;
    logic [AW-1:0] first_word;
    logic [AW-1:0] last_word;
    logic [WW-1:0] eff_word;
    logic [WW-1:0] lo_mask;
    logic [WW-1:0] hi_mask;
    logic [WW-1:0] avail;
    logic [SW-1:0] pos;
    logic          rd_en;
    logic          wr_en;
    logic [WW-1:0] wr_word;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_free_reg  <= bba_pkg::FIRST_FREE_RST;
            block_count_reg <= bba_pkg::BLOCK_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bba_pkg::REG_FIRST_FREE:  first_free_reg  <= cfg_data[IW-1:0];
                bba_pkg::REG_BLOCK_COUNT: block_count_reg <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // effective limit and word span of the window
    always_comb
    begin
        lim        = (block_count_reg > CW'(NBITS)) ? CW'(NBITS) : block_count_reg;
        lim_m1     = lim - CW'(1);
        first_word = AW'(first_free_reg >> SW);
        last_word  = AW'(lim_m1 >> SW);
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_cmd_reg <= command;
            item_id_reg  <= block_id;
        end
    end

    assign rd_en = cmd.scan_rd || cmd.free_rd;

    // read pointer and read pipeline flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg  <= '0;
            ex_ptr_reg  <= '0;
            ex_vld_reg  <= 1'b0;
            rd_wvld_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_item)
            begin
                rd_ptr_reg <= (command == bba_pkg::CMD_FREE) ? AW'(block_id >> SW) : first_word;
            end
            else if (cmd.scan_rd && (rd_ptr_reg != last_word))
            begin
                rd_ptr_reg <= rd_ptr_reg + AW'(1);
            end
            if (rd_en)
            begin
                ex_ptr_reg  <= rd_ptr_reg;
                rd_wvld_reg <= wvalid_reg[rd_ptr_reg];
            end
            ex_vld_reg <= cmd.scan_rd;
        end
    end

    // bitmap memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[ex_ptr_reg] <= wr_word;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

    // a word never written reads as all free
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wvalid_reg <= '0;
        end
        else if (wr_en)
        begin
            wvalid_reg[ex_ptr_reg] <= 1'b1;
        end
    end

    assign eff_word = rd_wvld_reg ? rd_data_reg : '0;

    // free bits inside the window
    always_comb
    begin
        lo_mask = (ex_ptr_reg == first_word) ? ({WW{1'b1}} << first_free_reg[SW-1:0])
                                             : {WW{1'b1}};
        hi_mask = (ex_ptr_reg == last_word) ? ({WW{1'b1}} >> (SW'(WW - 1) - lim_m1[SW-1:0]))
                                            : {WW{1'b1}};
        avail   = ~eff_word & lo_mask & hi_mask;
    end

    // lowest free bit
    always_comb
    begin
        pos = '0;
        for (int b = WW - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                pos = SW'(b);
            end
        end
    end

    // write-back word
    assign wr_en   = cmd.alloc_wr || cmd.free_wr;
    assign wr_word = cmd.alloc_wr ? (eff_word | (WW'(1) << pos))
                                  : (eff_word & ~(WW'(1) << item_id_reg[SW-1:0]));

    // result of the current item
    always_ff @(posedge clk)
    begin
        if (cmd.alloc_wr)
        begin
            res_block_reg  <= IW'({ex_ptr_reg, pos});
            res_status_reg <= bba_pkg::ST_ALLOCATED;
        end
        else if (cmd.free_wr)
        begin
            res_block_reg  <= item_id_reg;
            res_status_reg <= bba_pkg::ST_FREED;
        end
        else if (cmd.set_full)
        begin
            res_block_reg  <= '0;
            res_status_reg <= bba_pkg::ST_FULL;
        end
        else if (cmd.set_range)
        begin
            res_block_reg  <= item_id_reg;
            res_status_reg <= bba_pkg::ST_RANGE;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_block_reg  <= res_block_reg;
            out_status_reg <= res_status_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_block = out_block_reg;
    assign status       = out_status_reg;

    // status toward the controller
    always_comb
    begin
        stat.item_free     = (item_cmd_reg == bba_pkg::CMD_FREE);
        stat.window_empty  = ({1'b0, first_free_reg} >= lim);
        stat.free_in_range = (item_id_reg >= first_free_reg) && ({1'b0, item_id_reg} < lim);
        stat.ex_vld        = ex_vld_reg;
        stat.hit           = |avail;
        stat.ex_last       = (ex_ptr_reg == last_word);
        stat.out_busy      = out_valid_reg && !out_ready;
    end

endmodule

// ===== rtl/core/block_bitmap_allocator.sv =====
// First-fit block allocator over a used-bit bitmap, cleared at reset. An allocate beat
// returns the lowest clear block in [first_free_block, min(block_count, MAX_BLOCKS, 1024))
// and marks it used, or status full with block 0; a free beat clears the given block if it
// lies in that window and reports it freed, otherwise out of range. Items are handled one
// at a time. The bitmap sits in a memory of 64-bit words read one word per cycle. An allocate
// scans words from the word of first_free_block to the hit or to the end of the window (at
// most 16 for 1024 blocks) and writes the hit word back; a free inside the window reads its
// word and writes it back, and a free out of range or an allocate on an empty window goes
// straight to its result. The input is ready again in the same cycle as the result appears. A
// finished result is held in an output register, and in_ready returns once it has been handed
// there; while a result waits there unaccepted, the next one waits in its last step. No
// clearing pass is needed after reset.
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bba_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            command,
    input  logic [bba_pkg::ID_W-1:0]        block_id,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [bba_pkg::ID_W-1:0]        result_block,
    output logic [bba_pkg::STATUS_W-1:0]    status
);

    bba_pkg::dp_cmd_t  cmd;
    bba_pkg::dp_stat_t stat;

    // sequencing
    bba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // bitmap, registers and result path
    bba_dpath #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .command      (command),
        .block_id     (block_id),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_block (result_block),
        .status       (status),
        .cmd          (cmd),
        .stat         (stat)
    );

`ifndef SYNTH
    // a full report never carries a block index
    a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == bba_pkg::ST_FULL)) |-> (result_block == '0))
        else $error("full result with nonzero block");

    // one item at a time: the input closes right after a beat
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after a beat");

    // a new result only lands in an empty or draining output slot
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(result_block) && $stable(status)))
        else $error("pending result overwritten");
`endif

endmodule
